/* hdl/e2h_pkg.sv */
package e2h_pkg;

  // Angle and fixed-point formats
  localparam int ANGLE_BITS = 32;
  localparam int FRAC_BITS  = 30;
  localparam int DW         = 36;   // datapath width for sines, products, vectors
  localparam int ZW         = 34;   // residual angle width in the CORDIC cells
  localparam int PW         = 2 * DW;
  localparam int NCELL      = FRAC_BITS;
  localparam int SHIFT_W    = $clog2(NCELL);

  // 1/K in Q40, 1/(2 pi) in Q64
  localparam logic [63:0] INVK_Q40   = 64'd667681663043;
  localparam logic [63:0] INV2PI_Q64 = 64'h28BE60DB9391054A;
  localparam logic [63:0] INV_GAIN   = (INVK_Q40 + (64'd1 << (40 - FRAC_BITS - 1)))
                                       >> (40 - FRAC_BITS);
  // about 1e-5 in Q30
  localparam logic [63:0] LIMIT_T    = ((64'd1 << FRAC_BITS) + 64'd50000) / 64'd100000;

  localparam logic signed [DW-1:0] ONE_Q     = DW'(64'd1 << FRAC_BITS);
  localparam logic [ANGLE_BITS-1:0] HALF_A   = ANGLE_BITS'(64'd1 << (ANGLE_BITS - 1));
  localparam logic [ANGLE_BITS-1:0] QUART_A  = ANGLE_BITS'(64'd1 << (ANGLE_BITS - 2));

  typedef enum logic [1:0] {
    ST_NORMAL  = 2'd0,
    ST_ZENITH  = 2'd1,
    ST_AZ_TINY = 2'd2
  } status_t;

  typedef logic [ANGLE_BITS-1:0] atab_t [NCELL];

  // Rotation cell state
  typedef struct packed {
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 flip;
  } rot_t;

  // Vectoring cell state
  typedef struct packed {
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 half;
  } vec_t;

  // CORDIC angle table: Taylor series of atan in Q62, scaled to turns
  function automatic atab_t build_atab();
    atab_t        tab;
    logic [63:0]  r;
    logic [63:0]  term;
    logic [63:0]  t;
    logic [127:0] p;
    int           e;
    for (int i = 0; i < NCELL; i++) begin
      if (i == 0) begin
        t = 64'd1 << 61;
      end else begin
        r = '0;
        for (int k = 0; k < 32; k++) begin
          e = i * (2 * k + 1);
          if (e <= 62) begin
            term = (64'd1 << (62 - e)) / 64'(2 * k + 1);
            if (k % 2 == 1) r = r - term;
            else r = r + term;
          end
        end
        p = {64'd0, r} * {64'd0, INV2PI_Q64} + (128'd1 << 61);
        t = p[125:62];
      end
      tab[i] = ANGLE_BITS'((t + (64'd1 << (63 - ANGLE_BITS))) >> (64 - ANGLE_BITS));
    end
    return tab;
  endfunction

  localparam atab_t ATAN_TAB = build_atab();

  // Fixed-point product, magnitude rounded half up, sign applied after
  function automatic logic signed [DW-1:0] mulq(input logic signed [DW-1:0] a,
                                                input logic signed [DW-1:0] b);
    logic [DW-1:0] ma;
    logic [DW-1:0] mb;
    logic [PW-1:0] p;
    logic [PW-1:0] r;
    ma = a[DW-1] ? DW'(-a) : DW'(a);
    mb = b[DW-1] ? DW'(-b) : DW'(b);
    p  = PW'(ma) * PW'(mb);
    r  = (p + (PW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    return (a[DW-1] ^ b[DW-1]) ? -$signed(r[DW-1:0]) : $signed(r[DW-1:0]);
  endfunction

endpackage

/* hdl/e2h_rot_cell.sv */
module e2h_rot_cell (
  input  logic                            clk,
  input  logic                            en,
  input  logic [e2h_pkg::SHIFT_W-1:0]     shift,
  input  logic [e2h_pkg::ANGLE_BITS-1:0]  angle,
  input  e2h_pkg::rot_t                   d_in,
  output e2h_pkg::rot_t                   d_out
);
  import e2h_pkg::*;

  logic signed [DW-1:0] dx;
  logic signed [DW-1:0] dy;
  logic signed [ZW-1:0] da;
  rot_t                 st_nxt;
  rot_t                 st_r;

  // one rotation step, direction from residual sign
  always_comb begin
    dx = d_in.y >>> shift;
    dy = d_in.x >>> shift;
    da = ZW'(angle);
    st_nxt = d_in;
    if (!d_in.z[ZW-1]) begin
      st_nxt.x = d_in.x - dx;
      st_nxt.y = d_in.y + dy;
      st_nxt.z = d_in.z - da;
    end else begin
      st_nxt.x = d_in.x + dx;
      st_nxt.y = d_in.y - dy;
      st_nxt.z = d_in.z + da;
    end
  end

  always_ff @(posedge clk) begin
    if (en) st_r <= st_nxt;
  end

  assign d_out = st_r;

endmodule

/* hdl/e2h_vec_cell.sv */
module e2h_vec_cell (
  input  logic                            clk,
  input  logic                            en,
  input  logic [e2h_pkg::SHIFT_W-1:0]     shift,
  input  logic [e2h_pkg::ANGLE_BITS-1:0]  angle,
  input  e2h_pkg::vec_t                   d_in,
  output e2h_pkg::vec_t                   d_out
);
  import e2h_pkg::*;

  logic signed [DW-1:0] dx;
  logic signed [DW-1:0] dy;
  logic signed [ZW-1:0] da;
  vec_t                 st_nxt;
  vec_t                 st_r;

  // one vectoring step, drives y toward zero
  always_comb begin
    dx = d_in.y >>> shift;
    dy = d_in.x >>> shift;
    da = ZW'(angle);
    st_nxt = d_in;
    if (!d_in.y[DW-1]) begin
      st_nxt.x = d_in.x + dx;
      st_nxt.y = d_in.y - dy;
      st_nxt.z = d_in.z + da;
    end else begin
      st_nxt.x = d_in.x - dx;
      st_nxt.y = d_in.y + dy;
      st_nxt.z = d_in.z - da;
    end
  end

  always_ff @(posedge clk) begin
    if (en) st_r <= st_nxt;
  end

  assign d_out = st_r;

endmodule

/* hdl/e2h_sincos.sv */
module e2h_sincos (
  input  logic                            clk,
  input  logic                            en,
  input  logic [e2h_pkg::ANGLE_BITS-1:0]  angle,
  output logic signed [e2h_pkg::DW-1:0]   sn,
  output logic signed [e2h_pkg::DW-1:0]   cs
);
  import e2h_pkg::*;

  rot_t                  chain [NCELL+1];
  logic                  flip;
  logic [ANGLE_BITS-1:0] a_red;

  // fold into [-quarter, quarter) by a half-turn flip
  always_comb begin
    flip  = (angle + QUART_A) >= HALF_A;
    a_red = flip ? (angle - HALF_A) : angle;
    chain[0].x    = DW'(INV_GAIN);
    chain[0].y    = '0;
    chain[0].z    = ZW'($signed(a_red));
    chain[0].flip = flip;
  end

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    e2h_rot_cell u_cell (
      .clk  (clk),
      .en   (en),
      .shift(SHIFT_W'(i)),
      .angle(ATAN_TAB[i]),
      .d_in (chain[i]),
      .d_out(chain[i+1])
    );
  end

  // undo the flip on the way out
  assign sn = chain[NCELL].flip ? -chain[NCELL].y : chain[NCELL].y;
  assign cs = chain[NCELL].flip ? -chain[NCELL].x : chain[NCELL].x;

endmodule

/* hdl/e2h_vector.sv */
module e2h_vector (
  input  logic                            clk,
  input  logic                            en,
  input  logic signed [e2h_pkg::DW-1:0]   x_in,
  input  logic signed [e2h_pkg::DW-1:0]   y_in,
  output logic [e2h_pkg::ANGLE_BITS-1:0]  ang,
  output logic signed [e2h_pkg::DW-1:0]   x_out
);
  import e2h_pkg::*;

  vec_t chain [NCELL+1];

  // negative x: turn by a half turn first
  always_comb begin
    chain[0].half = x_in[DW-1];
    chain[0].x    = x_in[DW-1] ? -x_in : x_in;
    chain[0].y    = x_in[DW-1] ? -y_in : y_in;
    chain[0].z    = '0;
  end

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    e2h_vec_cell u_cell (
      .clk  (clk),
      .en   (en),
      .shift(SHIFT_W'(i)),
      .angle(ATAN_TAB[i]),
      .d_in (chain[i]),
      .d_out(chain[i+1])
    );
  end

  assign ang   = (chain[NCELL].half ? HALF_A : '0) + chain[NCELL].z[ANGLE_BITS-1:0];
  assign x_out = chain[NCELL].x;

endmodule

/* hdl/equatorial_to_horizontal.sv */
// Equatorial to horizontal conversion: each input beat (right ascension,
// declination, sidereal angle) yields one output beat (altitude, azimuth,
// status), one beat per cycle unless the output stalls. Path from input
// accept to output valid: three 30-cell rotation CORDIC rows for the sines
// and cosines of latitude, declination and hour angle, three product stages,
// a 30-cell vectoring row for azimuth and zenith distance, a gain stage, a
// status stage, a second 30-cell vectoring row for altitude and the output
// register. A two-entry output buffer keeps the pipeline moving while a
// result waits. Observer longitude (0x0) and latitude (0x4) are written
// over the APB port and must only change while the pipeline is empty.
module equatorial_to_horizontal (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // object_ra[31:0], object_dec[63:32], sidereal_angle[95:64]
  // output stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // altitude[31:0], azimuth[63:32]
  output logic [1:0]  out_tuser,  // status[1:0]
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import e2h_pkg::*;

  localparam int PIPE_LEN = 3 * NCELL + 5;
  localparam int V1_POS   = NCELL + 3;     // first vectoring row entry
  localparam int Z_POS    = 2 * NCELL + 3;
  localparam int ST_POS   = 2 * NCELL + 4;

  // configuration registers
  logic [31:0] lon_r;
  logic [31:0] lat_r;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_paddr[2] ? lat_r : lon_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lon_r <= '0;
      lat_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      if (cfg_paddr[2]) lat_r <= cfg_pwdata;
      else lon_r <= cfg_pwdata;
    end
  end

  // pipeline advance and valid tracking
  logic                en;
  logic                skid_vld_r;
  logic                out_vld_r;
  logic [PIPE_LEN-1:0] vld_r;

  assign en        = !skid_vld_r;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[PIPE_LEN-2:0], in_tvalid};
    end
  end

  // hour angle and sine/cosine rows
  logic [31:0]          ra;
  logic [31:0]          dec;
  logic [31:0]          sid;
  logic [31:0]          ha;
  logic signed [DW-1:0] sl, cl, sd, cd, sh, ch;

  assign ra  = in_tdata[31:0];
  assign dec = in_tdata[63:32];
  assign sid = in_tdata[95:64];
  assign ha  = sid - lon_r - ra;

  e2h_sincos u_lat (.clk(clk), .en(en), .angle(lat_r), .sn(sl), .cs(cl));
  e2h_sincos u_dec (.clk(clk), .en(en), .angle(dec),   .sn(sd), .cs(cd));
  e2h_sincos u_ha  (.clk(clk), .en(en), .angle(ha),    .sn(sh), .cs(ch));

  // product stages
  logic signed [DW-1:0] m1_cdch_r, m1_slsd_r, m1_clsd_r, m1_ps_r, m1_sl_r, m1_cl_r;
  logic signed [DW-1:0] m2_clcdch_r, m2_slcdch_r, m2_slsd_r, m2_clsd_r, m2_ps_r;
  logic signed [DW-1:0] m3_a_r, m3_pc_r, m3_ps_r;
  logic signed [DW-1:0] a_sum;

  assign a_sum = m2_slsd_r + m2_clcdch_r;

  always_ff @(posedge clk) begin
    if (en) begin
      m1_cdch_r   <= mulq(cd, ch);
      m1_slsd_r   <= mulq(sl, sd);
      m1_clsd_r   <= mulq(cl, sd);
      m1_ps_r     <= mulq(cd, sh);
      m1_sl_r     <= sl;
      m1_cl_r     <= cl;
      m2_clcdch_r <= mulq(m1_cl_r, m1_cdch_r);
      m2_slcdch_r <= mulq(m1_sl_r, m1_cdch_r);
      m2_slsd_r   <= m1_slsd_r;
      m2_clsd_r   <= m1_clsd_r;
      m2_ps_r     <= m1_ps_r;
      // clamp A to [-1, 1]
      if (a_sum > ONE_Q) m3_a_r <= ONE_Q;
      else if (a_sum < -ONE_Q) m3_a_r <= -ONE_Q;
      else m3_a_r <= a_sum;
      m3_pc_r     <= m2_slcdch_r - m2_clsd_r;
      m3_ps_r     <= m2_ps_r;
    end
  end

  // azimuth / zenith distance row, with A and As' riding alongside
  logic [ANGLE_BITS-1:0] v1_ang;
  logic signed [DW-1:0]  v1_x;
  logic signed [DW-1:0]  a_dly_r  [NCELL];
  logic signed [DW-1:0]  ps_dly_r [NCELL];

  e2h_vector u_az (
    .clk(clk), .en(en), .x_in(m3_pc_r), .y_in(m3_ps_r), .ang(v1_ang), .x_out(v1_x)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      a_dly_r[0]  <= m3_a_r;
      ps_dly_r[0] <= m3_ps_r;
      for (int j = 1; j < NCELL; j++) begin
        a_dly_r[j]  <= a_dly_r[j-1];
        ps_dly_r[j] <= ps_dly_r[j-1];
      end
    end
  end

  // gain correction of the vector length
  logic signed [DW-1:0]  z_zs_r, z_a_r, z_ps_r;
  logic [ANGLE_BITS-1:0] z_az_r;

  always_ff @(posedge clk) begin
    if (en) begin
      z_zs_r <= mulq(v1_x, DW'(INV_GAIN));
      z_a_r  <= a_dly_r[NCELL-1];
      z_ps_r <= ps_dly_r[NCELL-1];
      z_az_r <= v1_ang;
    end
  end

  // special cases: near zenith/nadir, tiny azimuth sine
  logic [DW-1:0]         ps_mag;
  logic [PW-1:0]         ps_lhs;
  logic [PW-1:0]         zs_rhs;
  logic                  zs_small;
  logic                  lat_pos;
  status_t               st_nxt;
  logic [ANGLE_BITS-1:0] az_nxt;
  logic signed [DW-1:0]  st_zs_r, st_a_r;
  status_t               st_status_r;
  logic [ANGLE_BITS-1:0] st_az_r;

  always_comb begin
    ps_mag   = z_ps_r[DW-1] ? DW'(-z_ps_r) : DW'(z_ps_r);
    ps_lhs   = PW'(ps_mag) << FRAC_BITS;
    zs_rhs   = PW'(LIMIT_T) * PW'($unsigned(z_zs_r));
    zs_small = z_zs_r < $signed(DW'(LIMIT_T));
    lat_pos  = !lat_r[31] && (lat_r != '0);
    st_nxt   = ST_NORMAL;
    az_nxt   = z_az_r;
    if (zs_small) begin
      st_nxt = ST_ZENITH;
      az_nxt = lat_pos ? HALF_A : '0;
    end else if (ps_lhs < zs_rhs) begin
      st_nxt = ST_AZ_TINY;
      az_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_zs_r     <= z_zs_r;
      st_a_r      <= z_a_r;
      st_status_r <= st_nxt;
      st_az_r     <= az_nxt;
    end
  end

  // altitude row, with azimuth and status riding alongside
  logic [ANGLE_BITS-1:0] v2_ang;
  logic signed [DW-1:0]  v2_x;
  status_t               sts_dly_r [NCELL];
  logic [ANGLE_BITS-1:0] az_dly_r  [NCELL];

  e2h_vector u_alt (
    .clk(clk), .en(en), .x_in(st_zs_r), .y_in(st_a_r), .ang(v2_ang), .x_out(v2_x)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sts_dly_r[0] <= st_status_r;
      az_dly_r[0]  <= st_az_r;
      for (int j = 1; j < NCELL; j++) begin
        sts_dly_r[j] <= sts_dly_r[j-1];
        az_dly_r[j]  <= az_dly_r[j-1];
      end
    end
  end

  // clamp altitude to a quarter turn either way
  logic signed [ANGLE_BITS-1:0] alt_s;
  logic [ANGLE_BITS-1:0]        alt_fin;
  logic [65:0]                  res;
  logic                         unused_len;

  assign unused_len = ^v2_x;   // length of the altitude vector is not needed

  always_comb begin
    alt_s = $signed(v2_ang);
    if (alt_s > $signed(QUART_A)) alt_fin = QUART_A;
    else if (alt_s < -$signed(QUART_A)) alt_fin = -QUART_A;
    else alt_fin = v2_ang;
    res = {sts_dly_r[NCELL-1], az_dly_r[NCELL-1], alt_fin ^ {ANGLE_BITS{unused_len & 1'b0}}};
  end

  // output register plus skid entry
  logic [65:0] out_r;
  logic [65:0] skid_r;
  logic        pipe_out;

  assign pipe_out = en && vld_r[PIPE_LEN-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (out_tready) begin
        out_r      <= skid_r;
        skid_vld_r <= 1'b0;
      end
    end else if (pipe_out) begin
      if (!out_vld_r || out_tready) begin
        out_r     <= res;
        out_vld_r <= 1'b1;
      end else begin
        skid_r     <= res;
        skid_vld_r <= 1'b1;
      end
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_r[63:0];
  assign out_tuser  = out_r[65:64];

endmodule
